### hdl/nms_pkg.sv
// shared widths, constants and types for the 3x3 neighbour mean smoother
`default_nettype none

package nms_pkg;

	localparam int ELEMENT_BITS = 16;
	localparam int MAX_COLUMNS  = 32;
	localparam int MAX_ROWS     = 1024;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLUMNS);
	localparam int ROW_CFG_W = 11;
	localparam int COL_CFG_W = 6;

	localparam int CFG_DATA_W  = ROW_CFG_W;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = CFG_INDEX_W'(1);

	localparam int SUM_W     = ELEMENT_BITS + 3;
	localparam int CNT_W     = 4;
	localparam int FRAC_BITS = 8;
	localparam int N_W       = SUM_W + FRAC_BITS;
	localparam int MEAN_W    = 24;

	// reciprocal multipliers, exact for every dividend below 2**N_W
	localparam int K3   = N_W + 2;
	localparam int K5   = N_W + 3;
	localparam int M_W  = N_W + 1;
	localparam logic [M_W-1:0] M3 = M_W'(((64'd1 << K3) + 64'd2) / 64'd3);
	localparam logic [M_W-1:0] M5 = M_W'(((64'd1 << K5) + 64'd4) / 64'd5);
	localparam int PROD_W = N_W + M_W;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             last;
	} nms_tag_t;

endpackage

`default_nettype wire

### hdl/nms_mean_unit.sv
// rounding division of a neighbour sum by its count, saturation and output register
`default_nettype none

module nms_mean_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [nms_pkg::SUM_W-1:0]    sum,
	input  logic [nms_pkg::CNT_W-1:0]           cnt,
	input  nms_pkg::nms_tag_t                   tag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [nms_pkg::MEAN_W-1:0]   mean_q8,
	output logic                                no_neighbours,
	output logic [nms_pkg::ROW_W-1:0]           out_row,
	output logic [nms_pkg::COL_W-1:0]           out_column,
	output logic                                last_of_matrix
);
	import nms_pkg::*;

	typedef enum logic [2:0] {
		DIV_ONE,
		DIV_TWO,
		DIV_THREE,
		DIV_FIVE,
		DIV_EIGHT
	} div_t;

	localparam int QX_W = ((N_W > MEAN_W) ? N_W : MEAN_W) + 1;
	localparam logic [QX_W-1:0] NEG_LIMIT = QX_W'(1) << (MEAN_W - 1);
	localparam logic [QX_W-1:0] POS_LIMIT = NEG_LIMIT - QX_W'(1);

	logic v_s3, v_s4, v_s5;
	logic out_free, s4_free, s3_free;

	logic [N_W-1:0]    n_s3;
	logic              neg_s3;
	div_t              div_s3;
	logic              none_s3;
	nms_tag_t          tag_s3;

	logic [PROD_W-1:0] prod_s4;
	logic              neg_s4;
	div_t              div_s4;
	logic              none_s4;
	nms_tag_t          tag_s4;

	logic signed [MEAN_W-1:0] mean_s5;
	logic                     none_s5;
	nms_tag_t                 tag_s5;

	logic              neg_c;
	logic [SUM_W-1:0]  mag_c;
	logic [N_W-1:0]    n_c;
	div_t              div_c;
	logic [M_W-1:0]    mult_c;
	logic [PROD_W-1:0] prod_c;
	logic [N_W-1:0]    q_c;
	logic [QX_W-1:0]   qx_c;
	logic [MEAN_W-1:0] mean_c;

	assign out_free   = !v_s5 || !out_stall;
	assign s4_free    = !v_s4 || out_free;
	assign s3_free    = !v_s3 || s4_free;
	assign item_stall = !s3_free;

	// magnitude, rounding offset and divisor class
	always_comb begin
		neg_c = sum[SUM_W-1];
		mag_c = neg_c ? SUM_W'(-sum) : SUM_W'(sum);
		n_c   = {mag_c, FRAC_BITS'(0)} + N_W'(cnt >> 1);
		case (cnt)
			CNT_W'(2): div_c = DIV_TWO;
			CNT_W'(3): div_c = DIV_THREE;
			CNT_W'(5): div_c = DIV_FIVE;
			CNT_W'(8): div_c = DIV_EIGHT;
			default:   div_c = DIV_ONE;
		endcase
	end

	always_comb begin
		unique case (div_s3)
			DIV_THREE: mult_c = M3;
			DIV_FIVE:  mult_c = M5;
			default:   mult_c = M_W'(1);
		endcase
		prod_c = PROD_W'(n_s3) * PROD_W'(mult_c);
	end

	always_comb begin
		unique case (div_s4)
			DIV_TWO:   q_c = N_W'(prod_s4 >> 1);
			DIV_EIGHT: q_c = N_W'(prod_s4 >> 3);
			DIV_THREE: q_c = N_W'(prod_s4 >> K3);
			DIV_FIVE:  q_c = N_W'(prod_s4 >> K5);
			default:   q_c = N_W'(prod_s4);
		endcase
		qx_c = QX_W'(q_c);
		if (neg_s4) begin
			mean_c = (qx_c > NEG_LIMIT) ? MEAN_W'(NEG_LIMIT) : MEAN_W'(-qx_c);
		end else begin
			mean_c = (qx_c > POS_LIMIT) ? MEAN_W'(POS_LIMIT) : MEAN_W'(qx_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (s3_free) begin
				v_s3 <= item_valid;
			end
			if (s4_free) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && s3_free) begin
			n_s3    <= n_c;
			neg_s3  <= neg_c;
			div_s3  <= div_c;
			none_s3 <= (cnt == '0);
			tag_s3  <= tag;
		end
		if (v_s3 && s4_free) begin
			prod_s4 <= prod_c;
			neg_s4  <= neg_s3;
			div_s4  <= div_s3;
			none_s4 <= none_s3;
			tag_s4  <= tag_s3;
		end
		if (v_s4 && out_free) begin
			mean_s5 <= mean_c;
			none_s5 <= none_s4;
			tag_s5  <= tag_s4;
		end
	end

	assign out_valid      = v_s5;
	assign mean_q8        = mean_s5;
	assign no_neighbours  = none_s5;
	assign out_row        = tag_s5.row;
	assign out_column     = tag_s5.column;
	assign last_of_matrix = tag_s5.last;

endmodule

`default_nettype wire

### hdl/neighbour_mean_smoothing_3x3_top.sv
// top level of the 3x3 neighbour mean smoother: line buffers, window, result sequencing
//
// channel   direction  handshake             payload
// in        to block   in_valid / in_stall   element_value
// out       from block out_valid / out_stall mean_q8, no_neighbours, out_row, out_column,
//                                            last_of_matrix
// cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one element per cycle unless in_stall is raised; an element that completes k results
// (last column, last row) holds the input while more than one of its results is pending,
// as one result a cycle leaves the window while the divide pipeline is free; the first
// result of an element passes the window, sum and mean unit registers before it is valid
// reset clears counters and pipeline valids; line buffers and window are not reset
// output stall back-pressures through the divide pipeline to in_stall
`default_nettype none

module neighbour_mean_smoothing_3x3_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [nms_pkg::ELEMENT_BITS-1:0] element_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [nms_pkg::MEAN_W-1:0]     mean_q8,
	output logic                                  no_neighbours,
	output logic [nms_pkg::ROW_W-1:0]             out_row,
	output logic [nms_pkg::COL_W-1:0]             out_column,
	output logic                                  last_of_matrix,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nms_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [nms_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import nms_pkg::*;

	typedef struct packed {
		logic [ELEMENT_BITS-1:0] upper;
		logic [ELEMENT_BITS-1:0] middle;
	} line_t;

	line_t lbuf_q [MAX_COLUMNS];

	logic [ROW_W-1:0] rows_last_q, r_q;
	logic [COL_W-1:0] cols_last_q, c_q;

	logic signed [ELEMENT_BITS-1:0] win_s1 [3][3];
	logic [ROW_W-1:0] r_s1;
	logic [COL_W-1:0] c_s1;
	logic [3:0]       pend_s1;

	logic                    v_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic [CNT_W-1:0]        cnt_s2;
	nms_tag_t                tag_s2;

	logic unit_stall, s2_free, emit, accept, cfg_write;
	logic [3:0] low_bit, pend_new;
	logic [1:0] sel;
	logic [2:0] row_ok, col_ok;
	logic signed [SUM_W-1:0] sum_c;
	logic [CNT_W-1:0]        cnt_c;
	nms_tag_t                tag_c;
	logic [ROW_CFG_W-1:0] rows_cfg;
	logic [COL_CFG_W-1:0] cols_cfg;
	logic [ROW_W-1:0]     rows_last_c;
	logic [COL_W-1:0]     cols_last_c;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready
		&& (cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COLUMN_COUNT);

	assign s2_free  = !v_s2 || !unit_stall;
	assign emit     = (pend_s1 != '0) && s2_free;
	assign low_bit  = pend_s1 & (~pend_s1 + 4'd1);
	assign in_stall = (pend_s1 != '0) && !(s2_free && $onehot(pend_s1));
	assign accept   = in_valid && !in_stall;

	assign pend_new[0] = (r_q != '0) && (c_q != '0);
	assign pend_new[1] = (r_q != '0) && (c_q == cols_last_q);
	assign pend_new[2] = (r_q == rows_last_q) && (c_q != '0);
	assign pend_new[3] = (r_q == rows_last_q) && (c_q == cols_last_q);

	// effective sizes held as last index
	always_comb begin
		rows_cfg = cfg_data[ROW_CFG_W-1:0];
		cols_cfg = cfg_data[COL_CFG_W-1:0];
		if (rows_cfg == '0) begin
			rows_last_c = '0;
		end else if (rows_cfg > ROW_CFG_W'(MAX_ROWS)) begin
			rows_last_c = ROW_W'(MAX_ROWS - 1);
		end else begin
			rows_last_c = ROW_W'(rows_cfg - ROW_CFG_W'(1));
		end
		if (cols_cfg == '0) begin
			cols_last_c = '0;
		end else if (cols_cfg > COL_CFG_W'(MAX_COLUMNS)) begin
			cols_last_c = COL_W'(MAX_COLUMNS - 1);
		end else begin
			cols_last_c = COL_W'(cols_cfg - COL_CFG_W'(1));
		end
	end

	// neighbour sum for the lowest pending centre
	always_comb begin
		if (pend_s1[0]) begin
			sel = 2'd0;
		end else if (pend_s1[1]) begin
			sel = 2'd1;
		end else if (pend_s1[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
		row_ok = {1'b1, r_s1 != '0, r_s1 >= ROW_W'(2)};
		col_ok = {1'b1, c_s1 != '0, c_s1 >= COL_W'(2)};
		sum_c  = '0;
		cnt_c  = '0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				if (k >= int'(sel[1]) && j >= int'(sel[0])
					&& !(k == int'(sel[1]) + 1 && j == int'(sel[0]) + 1)
					&& row_ok[k] && col_ok[j]) begin
					sum_c = sum_c + SUM_W'(win_s1[k][j]);
					cnt_c = cnt_c + CNT_W'(1);
				end
			end
		end
		tag_c.row    = r_s1 - ROW_W'(1) + ROW_W'(sel[1]);
		tag_c.column = c_s1 - COL_W'(1) + COL_W'(sel[0]);
		tag_c.last   = (sel == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= '0;
			cols_last_q <= '0;
			r_q         <= '0;
			c_q         <= '0;
			pend_s1     <= '0;
			v_s2        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ROW_COUNT:    rows_last_q <= rows_last_c;
					CFG_COLUMN_COUNT: cols_last_q <= cols_last_c;
					default:          ;
				endcase
			end
			if (cfg_write) begin
				r_q <= '0;
				c_q <= '0;
			end else if (accept) begin
				if (c_q == cols_last_q) begin
					c_q <= '0;
					r_q <= (r_q == rows_last_q) ? '0 : r_q + ROW_W'(1);
				end else begin
					c_q <= c_q + COL_W'(1);
				end
			end
			if (accept) begin
				pend_s1 <= pend_new;
			end else if (emit) begin
				pend_s1 <= pend_s1 & ~low_bit;
			end
			if (s2_free) begin
				v_s2 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				win_s1[k][0] <= win_s1[k][1];
				win_s1[k][1] <= win_s1[k][2];
			end
			win_s1[0][2] <= lbuf_q[c_q].upper;
			win_s1[1][2] <= lbuf_q[c_q].middle;
			win_s1[2][2] <= element_value;
			lbuf_q[c_q]  <= {lbuf_q[c_q].middle, element_value};
			r_s1         <= r_q;
			c_s1         <= c_q;
		end
		if (emit) begin
			sum_s2 <= sum_c;
			cnt_s2 <= cnt_c;
			tag_s2 <= tag_c;
		end
	end

	nms_mean_unit u_mean (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (v_s2),
		.item_stall     (unit_stall),
		.sum            (sum_s2),
		.cnt            (cnt_s2),
		.tag            (tag_s2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mean_q8        (mean_q8),
		.no_neighbours  (no_neighbours),
		.out_row        (out_row),
		.out_column     (out_column),
		.last_of_matrix (last_of_matrix)
	);

`ifndef SYNTHESIS
	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_matrix |-> out_row == rows_last_q && out_column == cols_last_q)
		else $error("last result not at the final position");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_neighbours |-> mean_q8 == '0)
		else $error("mean not zero without neighbours");

	a_none_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_neighbours |-> rows_last_q == '0 && cols_last_q == '0)
		else $error("no neighbours outside a single element matrix");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pend_s1 != '0)
		else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire

### verif/neighbour_mean_smoothing_3x3_top_test.sv
// self-checking testbench for the 3x3 neighbour mean smoother: directed table, then random matrices
`default_nettype none

module neighbour_mean_smoothing_3x3_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nms_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 30;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 40;
	localparam longint MEAN_LIMIT = 64'sd1 <<< (MEAN_W - 1);

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = CFG_INDEX_W'(3);

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic              alone;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic              last;
	} smooth_result_t;

	typedef enum logic {STEP_ELEMENT, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t                     kind;
		logic [CFG_INDEX_W-1:0]         index;
		logic [CFG_DATA_W-1:0]          data;
		logic signed [ELEMENT_BITS-1:0] value;
		int                             n_typed;
		smooth_result_t                 typed0;
		smooth_result_t                 typed1;
	} directed_step_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	logic signed [ELEMENT_BITS-1:0] element_value = '0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic signed [MEAN_W-1:0]       mean_q8;
	logic                           no_neighbours;
	logic [ROW_W-1:0]               out_row;
	logic [COL_W-1:0]               out_column;
	logic                           last_of_matrix;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [CFG_INDEX_W-1:0]         cfg_index     = '0;
	logic [CFG_DATA_W-1:0]          cfg_data      = '0;

	// smoother state as the block should hold it
	int row_setting    = 1;
	int column_setting = 1;
	int line_above[MAX_COLUMNS];
	int line_current[MAX_COLUMNS];
	int window_px[3][3];
	int next_row       = 0;
	int next_column    = 0;

	smooth_result_t expected_means[$];
	smooth_result_t want;
	directed_step_t directed_steps[$];

	int cycle_count  = 0;
	int mismatches   = 0;
	int random_items = 0;
	int gap_odds     = 0;
	int stall_odds   = 0;
	int stall_left   = 0;

	neighbour_mean_smoothing_3x3_top dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.element_value,
		.out_valid,
		.out_stall,
		.mean_q8,
		.no_neighbours,
		.out_row,
		.out_column,
		.last_of_matrix,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int clamp_count(input int raw, input int limit);
		return raw == 0 ? 1 : (raw > limit ? limit : raw);
	endfunction

	function automatic smooth_result_t make_result(input int mean, input bit alone, input int row,
			input int column, input bit last);
		smooth_result_t res;
		res.mean   = MEAN_W'(mean);
		res.alone  = alone;
		res.row    = ROW_W'(row);
		res.column = COL_W'(column);
		res.last   = last;
		return res;
	endfunction

	function automatic void queue_expected(input smooth_result_t res);
		expected_means.insert(expected_means.size(), res);
	endfunction

	// mean of the in-matrix neighbours of the window cell (ro, co), centre left out
	function automatic smooth_result_t neighbour_mean(input int ro, input int co, input int r,
			input int c, input int rows, input int cols, input bit last);
		smooth_result_t res;
		longint total, mag, q, m;
		int cnt, ar, ac;
		total = 0;
		cnt   = 0;
		for (int k = ro - 1; k <= ro + 1; k++) begin
			for (int j = co - 1; j <= co + 1; j++) begin
				ar = r - 2 + k;
				ac = c - 2 + j;
				if (k >= 0 && k <= 2 && j >= 0 && j <= 2 && !(k == ro && j == co)
						&& ar >= 0 && ar < rows && ac >= 0 && ac < cols) begin
					total += window_px[k][j];
					cnt++;
				end
			end
		end
		if (cnt == 0) begin
			m = 0;
		end else begin
			mag = total < 0 ? -total : total;
			q   = ((mag << FRAC_BITS) + cnt / 2) / cnt;
			if (total < 0)
				m = q > MEAN_LIMIT ? -MEAN_LIMIT : -q;
			else
				m = q > MEAN_LIMIT - 1 ? MEAN_LIMIT - 1 : q;
		end
		res.mean   = m[MEAN_W-1:0];
		res.alone  = cnt == 0;
		res.row    = ROW_W'(r - 2 + ro);
		res.column = COL_W'(c - 2 + co);
		res.last   = last;
		return res;
	endfunction

	function automatic int smooth_element(input logic signed [ELEMENT_BITS-1:0] x,
			output smooth_result_t res[4]);
		int rows, cols, r, c, n;
		rows = clamp_count(row_setting, MAX_ROWS);
		cols = clamp_count(column_setting, MAX_COLUMNS);
		r    = next_row;
		c    = next_column;
		n    = 0;
		if (c >= cols) c = 0;
		if (r >= rows) r = 0;
		for (int k = 0; k < 3; k++) begin
			window_px[k][0] = window_px[k][1];
			window_px[k][1] = window_px[k][2];
		end
		window_px[0][2] = line_above[c];
		window_px[1][2] = line_current[c];
		window_px[2][2] = x;
		line_above[c]   = line_current[c];
		line_current[c] = x;
		// upper-left first, then right edge, bottom edge, and the closing corner
		if (r >= 1 && c >= 1) begin
			res[n] = neighbour_mean(1, 1, r, c, rows, cols, 1'b0);
			n++;
		end
		if (r >= 1 && c == cols - 1) begin
			res[n] = neighbour_mean(1, 2, r, c, rows, cols, 1'b0);
			n++;
		end
		if (r == rows - 1 && c >= 1) begin
			res[n] = neighbour_mean(2, 1, r, c, rows, cols, 1'b0);
			n++;
		end
		if (r == rows - 1 && c == cols - 1) begin
			res[n] = neighbour_mean(2, 2, r, c, rows, cols, 1'b1);
			n++;
		end
		if (c + 1 >= cols) begin
			c = 0;
			r = (r + 1 >= rows) ? 0 : r + 1;
		end else begin
			c++;
		end
		next_row    = r;
		next_column = c;
		return n;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_means.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0d column %0d",
					out_row, out_column));
			end else begin
				want = expected_means.pop_front();
				if (mean_q8 !== want.mean)
					report_mismatch($sformatf("mean_q8 %0d, want %0d at (%0d,%0d)",
						mean_q8, $signed(want.mean), want.row, want.column));
				if (no_neighbours !== want.alone)
					report_mismatch($sformatf("no_neighbours %b, want %b at (%0d,%0d)",
						no_neighbours, want.alone, want.row, want.column));
				if (out_row !== want.row)
					report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
				if (out_column !== want.column)
					report_mismatch($sformatf("out_column %0d, want %0d",
						out_column, want.column));
				if (last_of_matrix !== want.last)
					report_mismatch($sformatf("last_of_matrix %b, want %b at (%0d,%0d)",
						last_of_matrix, want.last, want.row, want.column));
			end
		end
	end

	// receiver back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (stall_odds > 0 && $urandom_range(99) < stall_odds) begin
			out_stall  = 1'b1;
			stall_left = $urandom_range(7);
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic send_element(input logic signed [ELEMENT_BITS-1:0] v, input int n_typed,
			input smooth_result_t typed0, input smooth_result_t typed1);
		smooth_result_t got[4];
		int n, gap;
		if (gap_odds > 0 && $urandom_range(99) < gap_odds) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid      = 1'b0;
			element_value = ELEMENT_BITS'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      = 1'b1;
		element_value = v;
		do @(posedge clk); while (in_stall);
		n = smooth_element(v, got);
		if (n_typed > 0) begin
			queue_expected(typed0);
			if (n_typed > 1)
				queue_expected(typed1);
		end else begin
			for (int i = 0; i < n; i++)
				queue_expected(got[i]);
		end
	endtask

	// only once the pipeline has drained
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_ROW_COUNT: begin
				row_setting = int'(data);
				next_row    = 0;
				next_column = 0;
			end
			CFG_COLUMN_COUNT: begin
				column_setting = int'(data[COL_CFG_W-1:0]);
				next_row       = 0;
				next_column    = 0;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [ELEMENT_BITS-1:0] pick_element();
		case ($urandom_range(15))
			0:       return {1'b1, {(ELEMENT_BITS-1){1'b0}}};
			1:       return {1'b0, {(ELEMENT_BITS-1){1'b1}}};
			2:       return '1;
			default: return ELEMENT_BITS'($urandom);
		endcase
	endfunction

	task automatic run_matrix(input int rows_raw, input int cols_raw, input bit cut_short);
		logic [CFG_DATA_W-1:0] data;
		smooth_result_t none;
		int total;
		none = '0;
		write_register(CFG_ROW_COUNT, CFG_DATA_W'(rows_raw));
		data = CFG_DATA_W'($urandom);
		data[COL_CFG_W-1:0] = COL_CFG_W'(cols_raw);
		write_register(CFG_COLUMN_COUNT, data);
		if ($urandom_range(4) == 0)
			write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
				CFG_DATA_W'($urandom));
		total = clamp_count(rows_raw, MAX_ROWS) * clamp_count(cols_raw, MAX_COLUMNS);
		if (cut_short)
			total = $urandom_range(0, total <= 40 ? total - 1 : 40);
		repeat (total) send_element(pick_element(), 0, none, none);
		random_items += total;
	endtask

	function automatic void add_element(input int v,
			input int n_typed, input smooth_result_t typed0, input smooth_result_t typed1);
		directed_step_t s;
		s.kind    = STEP_ELEMENT;
		s.index   = '0;
		s.data    = '0;
		s.value   = ELEMENT_BITS'(v);
		s.n_typed = n_typed;
		s.typed0  = typed0;
		s.typed1  = typed1;
		directed_steps.insert(directed_steps.size(), s);
	endfunction

	function automatic void add_write(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		directed_step_t s;
		s.kind    = STEP_WRITE;
		s.index   = index;
		s.data    = data;
		s.value   = '0;
		s.n_typed = 0;
		s.typed0  = '0;
		s.typed1  = '0;
		directed_steps.insert(directed_steps.size(), s);
	endfunction

	initial begin
		smooth_result_t solo, none;
		int rows_raw, cols_raw;
		bit cut_short;
		solo = make_result(0, 1'b1, 0, 0, 1'b1);
		none = '0;

		// out of reset the matrix is a single element
		add_element(32767, 1, solo, none);
		add_element(-32768, 1, solo, none);
		add_write(CFG_SPARE_HI, '1);
		add_element(1, 1, solo, none);
		// one row of two: each is the other's only neighbour
		add_write(CFG_COLUMN_COUNT, 11'd2);
		add_element(-32768, 0, none, none);
		add_element(32767, 2, make_result(8388352, 1'b0, 0, 0, 1'b0),
			make_result(-8388608, 1'b0, 0, 1, 1'b1));
		// zero columns acts as one column
		add_write(CFG_ROW_COUNT, 11'd2);
		add_write(CFG_COLUMN_COUNT, 11'd0);
		add_element(100, 0, none, none);
		add_element(-300, 2, make_result(-76800, 1'b0, 0, 0, 1'b0),
			make_result(25600, 1'b0, 1, 0, 1'b1));
		// zero rows acts as one row, upper data bits ignored for the column count
		add_write(CFG_ROW_COUNT, 11'd0);
		add_write(CFG_COLUMN_COUNT, 11'h7c2);
		add_element(5, 0, none, none);
		add_element(-7, 2, make_result(-1792, 1'b0, 0, 0, 1'b0),
			make_result(1280, 1'b0, 0, 1, 1'b1));
		// 3x3, broken off after four elements and restarted by a write
		add_write(CFG_ROW_COUNT, 11'd3);
		add_write(CFG_COLUMN_COUNT, 11'd3);
		add_element(11, 0, none, none);
		add_element(-22, 0, none, none);
		add_element(33, 0, none, none);
		add_element(-44, 0, none, none);
		add_write(CFG_SPARE_LO, '0);
		add_write(CFG_ROW_COUNT, 11'd3);
		add_element(32767, 0, none, none);
		add_element(-32768, 0, none, none);
		add_element(-1, 0, none, none);
		add_element(1, 0, none, none);
		add_element(0, 0, none, none);
		add_element(-3, 0, none, none);
		add_element(32767, 0, none, none);
		add_element(32767, 0, none, none);
		add_element(-32768, 0, none, none);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		gap_odds   = 30;
		stall_odds = 30;
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_WRITE)
				write_register(directed_steps[i].index, directed_steps[i].data);
			else
				send_element(directed_steps[i].value, directed_steps[i].n_typed,
					directed_steps[i].typed0, directed_steps[i].typed1);
		end

		while (random_items < RANDOM_ITEMS) begin
			gap_odds   = 20 * $urandom_range(3);
			stall_odds = 20 * $urandom_range(3);
			cut_short  = $urandom_range(5) == 0;
			case ($urandom_range(7))
				0: begin
					rows_raw = $urandom_range(6, 20);
					cols_raw = $urandom_range(1, 3);
				end
				1: begin
					rows_raw = $urandom_range(2);
					cols_raw = $urandom_range(1) ? MAX_COLUMNS : $urandom_range(33, 63);
				end
				2: begin
					rows_raw  = $urandom_range(1) ? MAX_ROWS : $urandom_range(1025, 2047);
					cols_raw  = $urandom_range(0, 4);
					cut_short = 1'b1;
				end
				default: begin
					rows_raw = $urandom_range(5);
					cols_raw = $urandom_range(8);
				end
			endcase
			run_matrix(rows_raw, cols_raw, cut_short);
		end

		// closing stretch at full rate: two rows of full width
		gap_odds   = 0;
		stall_odds = 0;
		run_matrix(2, MAX_COLUMNS, 1'b0);

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hdl/nms_pkg.sv
hdl/nms_mean_unit.sv
hdl/neighbour_mean_smoothing_3x3_top.sv
verif/neighbour_mean_smoothing_3x3_top_test.sv
